// ===== rtl/dti_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the depth table interpolator.
// No dependencies; the top level imports this package.
package dti_pkg;

	localparam int DATA_W  = 32;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int REM_W   = DATA_W + 2;
	localparam int PROD_W  = DIFF_W + DATA_W;
	localparam int VAL_W   = PROD_W + 1;
	localparam int SUM_W   = VAL_W + 1;
	localparam int RATE_SH = 30;

	typedef logic [1:0] op_t;
	localparam op_t OP_APPEND = 2'd0;
	localparam op_t OP_QUERY  = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_INTERP = 2'd0;
	localparam status_t ST_HELD   = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_ZSPAN  = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] east;
		logic signed [DATA_W-1:0] north;
		logic signed [DATA_W-1:0] depth;
	} layer_t;

	localparam int LAYER_W = $bits(layer_t);

	typedef struct packed {
		logic signed [DATA_W-1:0] base_z;
		logic signed [DATA_W-1:0] base_y;
		logic signed [DATA_W-1:0] base_x;
		logic signed [DATA_W-1:0] query_depth;
		logic signed [DATA_W-1:0] entry_east;
		logic signed [DATA_W-1:0] entry_north;
		logic signed [DATA_W-1:0] entry_depth;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] vel_z;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_x;
	} out_beat_t;

	localparam int IN_W       = $bits(in_beat_t);
	localparam int OUT_W      = $bits(out_beat_t);
	localparam int IN_USER_W  = $bits(op_t);
	localparam int OUT_USER_W = $bits(status_t) + 1;

endpackage

// ===== rtl/depth_table_interpolator.sv =====
`timescale 1ns / 1ps
// Depth table interpolator top level: layer table, scan sequencer, serial divider
// and shared multiply/add path. Depends on dti_pkg and dti_ram.
//
// Channel  Dir  Beat contents
// s_*      in   tuser: op; tdata: entry_depth, entry_north, entry_east, query_depth, base_x..z
// m_*      out  tdata: vel_x, vel_y, vel_z; tuser: status, append_overflow
//
// Append and clear beats are handled in the idle state and produce no result.
// An interpolating query scans the table entries through the RAM read port (at most
// TABLE_ENTRIES entries, each through S_ADDR and S_CMP), runs the bit-serial divider that
// forms the interpolation rate, then the multiply steps, and raises m_tvalid on write-back;
// s_tready returns in that same cycle.
// Held, zero-span and empty results skip the divider and the multiply steps.
// Reset empties the table and clears the overflow flag at once; there is no clearing pass.
// A result waiting on m_tready does not block new beats; only the final write-back waits.
module depth_table_interpolator #(
	parameter int TABLE_ENTRIES = 64,
	parameter int FRAC_BITS     = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_depth, entry_north, entry_east, query_depth, base_x, base_y, base_z
	input  logic [dti_pkg::IN_W-1:0]         s_tdata,
	// op
	input  logic [dti_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// vel_x, vel_y, vel_z
	output logic [dti_pkg::OUT_W-1:0]        m_tdata,
	// status, append_overflow
	output logic [dti_pkg::OUT_USER_W-1:0]   m_tuser
);

	import dti_pkg::*;

	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int CW    = $clog2(TABLE_ENTRIES + 1);
	localparam int DIV_W = DIFF_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic [CW-1:0]              FULL_COUNT = CW'(TABLE_ENTRIES);
	localparam logic [DIV_W-1:0]           RATE_LIM   = DIV_W'(1) << RATE_SH;
	localparam logic signed [DATA_W-1:0]   RATE_MAX   = DATA_W'(1) << RATE_SH;
	localparam logic [PROD_W-1:0]          ROUND_BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDR,
		S_CMP,
		S_SPAN,
		S_DIVSET,
		S_DIV,
		S_RATE,
		S_DIFF,
		S_MUL,
		S_SHIFT,
		S_ACC,
		S_SUMX,
		S_SUMY
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic                        ovf_q;
	logic [AW-1:0]               idx_q;
	logic signed [DATA_W-1:0]    query_q;
	logic signed [DATA_W-1:0]    base_x_q;
	logic signed [DATA_W-1:0]    base_y_q;
	logic signed [DATA_W-1:0]    base_z_q;
	layer_t                      prev_q;
	layer_t                      cur_q;
	status_t                     status_q;
	logic signed [DIFF_W-1:0]    span_q;
	logic signed [DIFF_W-1:0]    num_q;
	logic                        neg_q;
	logic [DIV_W-1:0]            dvd_q;
	logic [DIFF_W-1:0]           dvs_q;
	logic [REM_W-1:0]            rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic signed [DATA_W-1:0]    rate_q;
	logic                        sel_q;
	logic signed [DIFF_W-1:0]    diff_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [PROD_W-1:0]    delta_q;
	logic signed [VAL_W-1:0]     north_q;
	logic signed [VAL_W-1:0]     east_q;
	logic signed [DATA_W-1:0]    out_x_q;
	logic signed [DATA_W-1:0]    out_y_q;
	logic signed [DATA_W-1:0]    out_z_q;
	status_t                     out_st_q;
	logic                        out_ovf_q;
	logic                        m_valid_q;

	in_beat_t                    in_beat;
	op_t                         in_op;
	logic                        accept;
	logic                        wr_en;
	layer_t                      wr_layer;
	logic [LAYER_W-1:0]          rd_word;
	layer_t                      rd_layer;
	logic                        last_idx;
	logic [REM_W-1:0]            rem_sh;
	logic [REM_W-1:0]            rem_dif;
	logic                        q_bit;
	logic [DIFF_W-1:0]           num_mag;
	logic [DIFF_W-1:0]           span_mag;
	logic [DIV_W-1:0]            rate_mag;
	logic signed [DATA_W-1:0]    lo_sel;
	logic signed [DATA_W-1:0]    hi_sel;
	logic signed [PROD_W-1:0]    prod_bias;
	logic signed [VAL_W-1:0]     acc_val;
	logic signed [DATA_W-1:0]    base_sel;
	logic signed [VAL_W-1:0]     val_sel;
	logic signed [SUM_W-1:0]     sum_w;
	logic signed [DATA_W-1:0]    sum_sat;

	assign in_beat  = in_beat_t'(s_tdata);
	assign in_op    = op_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;

	assign wr_en          = accept && (in_op == OP_APPEND) && (count_q < FULL_COUNT);
	assign wr_layer.depth = in_beat.entry_depth;
	assign wr_layer.north = in_beat.entry_north;
	assign wr_layer.east  = in_beat.entry_east;

	dti_ram #(
		.WIDTH (LAYER_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_layer),
		.rd_addr (idx_q),
		.rd_data (rd_word)
	);

	assign rd_layer = layer_t'(rd_word);
	assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);

	// One restoring division step: quotient bits shift into the dividend register.
	assign rem_sh  = {rem_q[REM_W-2:0], dvd_q[DIV_W-1]};
	assign rem_dif = rem_sh - REM_W'(dvs_q);
	assign q_bit   = ~rem_dif[REM_W-1];

	assign num_mag  = num_q[DIFF_W-1] ? DIFF_W'(-num_q) : DIFF_W'(num_q);
	assign span_mag = span_q[DIFF_W-1] ? DIFF_W'(-span_q) : DIFF_W'(span_q);
	assign rate_mag = (dvd_q > RATE_LIM) ? RATE_LIM : dvd_q;

	assign lo_sel = sel_q ? prev_q.east : prev_q.north;
	assign hi_sel = sel_q ? cur_q.east : cur_q.north;

	// Bias negative products so the arithmetic shift truncates toward zero.
	assign prod_bias = prod_q + (prod_q[PROD_W-1] ? $signed(ROUND_BIAS) : $signed(PROD_W'(0)));
	assign acc_val   = VAL_W'(lo_sel) + VAL_W'(delta_q);

	assign base_sel = (state_q == S_SUMY) ? base_y_q : base_x_q;
	assign val_sel  = (state_q == S_SUMY) ? east_q : north_q;
	assign sum_w    = SUM_W'(base_sel) + SUM_W'(val_sel);

	always_comb begin
		if ((&sum_w[SUM_W-1:DATA_W-1]) || !(|sum_w[SUM_W-1:DATA_W-1])) begin
			sum_sat = sum_w[DATA_W-1:0];
		end else if (sum_w[SUM_W-1]) begin
			sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			query_q   <= '0;
			base_x_q  <= '0;
			base_y_q  <= '0;
			base_z_q  <= '0;
			prev_q    <= '0;
			cur_q     <= '0;
			status_q  <= ST_INTERP;
			span_q    <= '0;
			num_q     <= '0;
			neg_q     <= 1'b0;
			dvd_q     <= '0;
			dvs_q     <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			rate_q    <= '0;
			sel_q     <= 1'b0;
			diff_q    <= '0;
			prod_q    <= '0;
			delta_q   <= '0;
			north_q   <= '0;
			east_q    <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_z_q   <= '0;
			out_st_q  <= ST_INTERP;
			out_ovf_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_APPEND: begin
								if (count_q < FULL_COUNT) begin
									count_q <= count_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							OP_QUERY: begin
								query_q  <= in_beat.query_depth;
								base_x_q <= in_beat.base_x;
								base_y_q <= in_beat.base_y;
								base_z_q <= in_beat.base_z;
								idx_q    <= '0;
								if (count_q == '0) begin
									north_q  <= '0;
									east_q   <= '0;
									status_q <= ST_EMPTY;
									state_q  <= S_SUMX;
								end else begin
									state_q <= S_ADDR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ADDR: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((idx_q != '0) && (rd_layer.depth > query_q)) begin
						cur_q   <= rd_layer;
						state_q <= S_SPAN;
					end else if (last_idx) begin
						north_q  <= VAL_W'(rd_layer.north);
						east_q   <= VAL_W'(rd_layer.east);
						status_q <= ST_HELD;
						idx_q    <= '0;
						state_q  <= S_SUMX;
					end else begin
						prev_q  <= rd_layer;
						idx_q   <= idx_q + AW'(1);
						state_q <= S_ADDR;
					end
				end
				S_SPAN: begin
					span_q  <= DIFF_W'(cur_q.depth) - DIFF_W'(prev_q.depth);
					num_q   <= DIFF_W'(query_q) - DIFF_W'(prev_q.depth);
					idx_q   <= '0;
					state_q <= S_DIVSET;
				end
				S_DIVSET: begin
					if (span_q == '0) begin
						north_q  <= VAL_W'(prev_q.north);
						east_q   <= VAL_W'(prev_q.east);
						status_q <= ST_ZSPAN;
						state_q  <= S_SUMX;
					end else begin
						dvd_q   <= DIV_W'(num_mag) << FRAC_BITS;
						dvs_q   <= span_mag;
						rem_q   <= '0;
						neg_q   <= num_q[DIFF_W-1] ^ span_q[DIFF_W-1];
						cnt_q   <= CNT_W'(DIV_W);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= q_bit ? rem_dif : rem_sh;
					dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					rate_q   <= neg_q ? -DATA_W'(rate_mag) : DATA_W'(rate_mag);
					sel_q    <= 1'b0;
					status_q <= ST_INTERP;
					state_q  <= S_DIFF;
				end
				S_DIFF: begin
					diff_q  <= DIFF_W'(hi_sel) - DIFF_W'(lo_sel);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(diff_q) * PROD_W'(rate_q);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					delta_q <= prod_bias >>> FRAC_BITS;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!sel_q) begin
						north_q <= acc_val;
						sel_q   <= 1'b1;
						state_q <= S_DIFF;
					end else begin
						east_q  <= acc_val;
						state_q <= S_SUMX;
					end
				end
				S_SUMX: begin
					if (!m_valid_q || m_tready) begin
						out_x_q <= sum_sat;
						state_q <= S_SUMY;
					end
				end
				S_SUMY: begin
					out_y_q   <= sum_sat;
					out_z_q   <= base_z_q;
					out_st_q  <= status_q;
					out_ovf_q <= ovf_q;
					m_valid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_z_q, out_y_q, out_x_q};
	assign m_tuser  = {out_ovf_q, out_st_q};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count exceeds table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR || state_q == S_CMP) |-> (CW'(idx_q) < count_q))
		else $error("scan index beyond filled entries");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q != '0))
		else $error("divider running with zero step count");

	a_rate_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIFF) |-> (rate_q <= RATE_MAX && rate_q >= -RATE_MAX))
		else $error("interpolation rate outside its limit");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUMY) |-> !m_valid_q)
		else $error("result written over a pending beat");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == S_SUMY))
		else $error("result beat raised outside write-back");
`endif

endmodule

// ===== rtl/dti_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dti_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== tb/depth_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_table_interpolator: directed rows, then random table
// build/query/clear runs, checked beat by beat against a layer-table predictor or fixed row values.
// Depends on dti_pkg and the depth_table_interpolator RTL.
module depth_table_interpolator_tb;
	import dti_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int FRAC_BITS = 16;
	localparam op_t OP_NOP = 2'd3;
	localparam longint RATE_MAX = 64'sd1 << 30;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int HOLD_CYCLES = 1000;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT = 8000;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		status_t status;
		logic ovf;
	} vel_result_t;

	typedef struct {
		op_t op;
		in_beat_t beat;
		bit typed;
		vel_result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic [IN_USER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	logic signed [31:0] tbl_depth [TABLE_ENTRIES];
	logic signed [31:0] tbl_north [TABLE_ENTRIES];
	logic signed [31:0] tbl_east [TABLE_ENTRIES];
	int tbl_count;
	logic tbl_overflow;

	vel_result_t pending_vel[$];
	vel_result_t no_want;
	bit drv_typed;
	vel_result_t drv_want;
	int tx_idle_pct;
	int rx_idle_pct;
	int phase;
	int items_sent;
	int mismatches;
	int quiet_cycles;
	dir_row_t dir_rows [32];
	int n_rows;
	logic signed [31:0] seq_depths[$];
	logic signed [31:0] next_depth;

	depth_table_interpolator #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint blend(input longint lo, input longint hi, input longint rate);
		return lo + ((hi - lo) * rate) / (64'sd1 <<< FRAC_BITS);
	endfunction

	function automatic void step_layer_table(input op_t op, input in_beat_t b,
			output bit has_vel, output vel_result_t r);
		longint q;
		longint d0;
		longint span;
		longint rate;
		longint dn;
		longint de;
		int hit;
		has_vel = 0;
		dn = 0;
		de = 0;
		hit = 0;
		case (op)
			OP_APPEND: begin
				if (tbl_count < TABLE_ENTRIES) begin
					tbl_depth[tbl_count] = b.entry_depth;
					tbl_north[tbl_count] = b.entry_north;
					tbl_east[tbl_count] = b.entry_east;
					tbl_count++;
				end else begin
					tbl_overflow = 1;
				end
			end
			OP_CLEAR: begin
				tbl_count = 0;
				tbl_overflow = 0;
			end
			OP_QUERY: begin
				q = b.query_depth;
				if (tbl_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 1; i < tbl_count; i++)
						if (hit == 0 && longint'(tbl_depth[i]) > q) hit = i;
					if (hit == 0) begin
						dn = tbl_north[tbl_count-1];
						de = tbl_east[tbl_count-1];
						r.status = ST_HELD;
					end else begin
						d0 = tbl_depth[hit-1];
						span = longint'(tbl_depth[hit]) - d0;
						if (span == 0) begin
							dn = tbl_north[hit-1];
							de = tbl_east[hit-1];
							r.status = ST_ZSPAN;
						end else begin
							rate = ((q - d0) * (64'sd1 <<< FRAC_BITS)) / span;
							if (rate > RATE_MAX) rate = RATE_MAX;
							if (rate < -RATE_MAX) rate = -RATE_MAX;
							dn = blend(tbl_north[hit-1], tbl_north[hit], rate);
							de = blend(tbl_east[hit-1], tbl_east[hit], rate);
							r.status = ST_INTERP;
						end
					end
				end
				r.vx = clamp32(longint'(b.base_x) + dn);
				r.vy = clamp32(longint'(b.base_y) + de);
				r.vz = b.base_z;
				r.ovf = tbl_overflow;
				has_vel = 1;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic in_beat_t rand_beat();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic signed [31:0] pick_vel();
		if ($urandom_range(4) == 0) return $urandom;
		return int'($urandom_range(0, 1 << 23)) - (1 << 22);
	endfunction

	task automatic add_row(input op_t op, input logic [31:0] d, n, e, q, bx, by, bz);
		dir_rows[n_rows].op = op;
		dir_rows[n_rows].beat = {bz, by, bx, q, e, n, d};
		dir_rows[n_rows].typed = 0;
		n_rows++;
	endtask

	task automatic row_expect(input logic [31:0] vx, vy, vz, input status_t st,
			input logic ovf);
		dir_rows[n_rows-1].typed = 1;
		dir_rows[n_rows-1].want.vx = vx;
		dir_rows[n_rows-1].want.vy = vy;
		dir_rows[n_rows-1].want.vz = vz;
		dir_rows[n_rows-1].want.status = st;
		dir_rows[n_rows-1].want.ovf = ovf;
	endtask

	task automatic offer_beat(input op_t op, input in_beat_t b, input bit typed,
			input vel_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tdata = b;
		s_tuser = op;
		drv_typed = typed;
		drv_want = want;
		s_tvalid = 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op != OP_NOP) items_sent++;
	endtask

	// Appends a sorted run of layers (optionally after a clear) and then queries around it.
	task automatic run_layer_sequence(input int n_app, input int n_qry, input bit fresh);
		in_beat_t b;
		int j;
		int sel;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		if (fresh) begin
			offer_beat(OP_CLEAR, rand_beat(), 0, no_want);
			seq_depths.delete();
			next_depth = int'($urandom_range(0, 1 << 27)) - (1 << 26);
		end
		repeat (n_app) begin
			b = rand_beat();
			b.entry_depth = next_depth;
			b.entry_north = pick_vel();
			b.entry_east = pick_vel();
			offer_beat(OP_APPEND, b, 0, no_want);
			seq_depths.insert(seq_depths.size(), next_depth);
			if ($urandom_range(9) != 0) next_depth += $urandom_range(1, 1 << 22);
		end
		repeat (n_qry) begin
			b = rand_beat();
			b.base_x = pick_vel();
			b.base_y = pick_vel();
			sel = $urandom_range(99);
			if (seq_depths.size() == 0 || sel < 10) begin
				b.base_z = $urandom;
			end else if (sel < 50 && seq_depths.size() >= 2) begin
				j = $urandom_range(seq_depths.size() - 2);
				lo = seq_depths[j];
				hi = seq_depths[j+1];
				b.query_depth = lo + $urandom_range(hi - lo);
			end else if (sel < 65) begin
				b.query_depth = seq_depths[$urandom_range(seq_depths.size() - 1)];
			end else if (sel < 80) begin
				b.query_depth = seq_depths[0] - $urandom_range(1, 1 << 20);
			end else begin
				b.query_depth = seq_depths[$] + $urandom_range(0, 1 << 20);
			end
			offer_beat(OP_QUERY, b, 0, no_want);
		end
	endtask

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 0;
			end else if (phase == 2 && !hold_done) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES - 1;
				m_tready = 0;
			end else begin
				m_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		vel_result_t got;
		vel_result_t want;
		vel_result_t pred;
		out_beat_t ob;
		bit has_vel;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				ob = m_tdata;
				got.vx = ob.vel_x;
				got.vy = ob.vel_y;
				got.vz = ob.vel_z;
				got.status = m_tuser[1:0];
				got.ovf = m_tuser[2];
				if (pending_vel.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("check failed: result beat with no query pending, vel %h %h %h",
							got.vx, got.vy, got.vz);
				end else begin
					want = pending_vel.pop_front();
					if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
							got.status !== want.status || got.ovf !== want.ovf) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"check failed: expected %h %h %h st %0d ovf %0d,",
								" got %h %h %h st %0d ovf %0d"},
								want.vx, want.vy, want.vz, want.status, want.ovf,
								got.vx, got.vy, got.vz, got.status, got.ovf);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				step_layer_table(s_tuser, s_tdata, has_vel, pred);
				if (has_vel) begin
					if (drv_typed) pred = drv_want;
					pending_vel.insert(pending_vel.size(), pred);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int goal;
		int pick;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		drv_typed = 0;
		tbl_count = 0;
		tbl_overflow = 0;
		phase = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 65;
		n_rows = 0;

		add_row(OP_QUERY, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h12345678);
		row_expect(32'h7fffffff, 32'h80000000, 32'h12345678, ST_EMPTY, 0);
		add_row(OP_NOP, '1, '1, '1, '1, '1, '1, '1);
		add_row(OP_APPEND, 0, 32'h00010000, 32'hffff0000, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'hffff0000, 0, 0, 32'hffffffff);
		row_expect(32'h00010000, 32'hffff0000, 32'hffffffff, ST_HELD, 0);
		add_row(OP_APPEND, 32'h00010000, 32'h00030000, 32'h00010000, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'h00008000, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'h00010000, 0, 0, 0);
		row_expect(32'h00030000, 32'h00010000, 0, ST_HELD, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h00001234, 32'hfffff000, 0);
		add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_APPEND, 32'h00050000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
		add_row(OP_APPEND, 32'h00050000, 0, 0, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 0, 32'h00000001, 32'hffffffff, 0);
		row_expect(32'h7fffffff, 32'h80000000, 0, ST_ZSPAN, 0);
		add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_APPEND, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
		add_row(OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		add_row(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
		row_expect(32'hffffffff, 32'hffffffff, 0, ST_INTERP, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'h7ffffffe, 32'h00010000, 32'hffff0000, 0);
		add_row(OP_APPEND, 0, 32'h12340000, 32'hffffffff, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'h7fffffff, 0, 0, 0);
		row_expect(32'h12340000, 32'hffffffff, 0, ST_HELD, 0);
		add_row(OP_QUERY, 0, 0, 0, 32'hfffffffb, 0, 0, 0);
		add_row(OP_NOP, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1);
		add_row(OP_QUERY, 0, 0, 0, 32'h7fffffff, 32'h55555555, 32'haaaaaaaa, 32'hffffffff);
		row_expect(32'h55555555, 32'haaaaaaaa, 32'hffffffff, ST_EMPTY, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int k = 0; k < n_rows; k++)
			offer_beat(dir_rows[k].op, dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);

		for (int p = 0; p < 3; p++) begin
			phase = p;
			tx_idle_pct = (p == 0) ? 15 : (p == 1) ? 65 : 0;
			rx_idle_pct = (p == 0) ? 65 : (p == 1) ? 15 : 0;
			goal = items_sent + ITEMS_PER_PHASE;
			// A run that overfills the table sets the sticky overflow flag.
			if (p != 1) run_layer_sequence($urandom_range(66, 70), $urandom_range(4, 8), 1);
			while (items_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 15) begin
					repeat ($urandom_range(1, 4))
						offer_beat(op_t'($urandom_range(3)), rand_beat(), 0, no_want);
				end else begin
					run_layer_sequence($urandom_range(1, 8), $urandom_range(2, 8),
						$urandom_range(3) != 0);
				end
			end
		end

		@(negedge clk);
		s_tvalid = 0;
		while (pending_vel.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dti_pkg.sv
rtl/dti_ram.sv
rtl/depth_table_interpolator.sv
tb/depth_table_interpolator_tb.sv
